FILE: src/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the stride prefetch predictor.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int ADDR_W      = 64;
    localparam int MODE_W      = 2;
    localparam int M_TDATA_W   = 72;
    localparam int SPAN        = 10;
    localparam int SPAN_CNT_W  = $clog2(SPAN + 2);

    localparam logic [ADDR_W-1:0] RESET_STRIDE = 64'd64;

    localparam logic [MODE_W-1:0] MODE_ADAPTIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STRIDED  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RANDOM   = 2'd3;

    localparam logic REG_INITIAL_MODE   = 1'b0;
    localparam logic REG_INITIAL_STRIDE = 1'b1;

    localparam logic ACTION_RECORD  = 1'b0;
    localparam logic ACTION_PREDICT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic wr_hist;
        logic ana_start;
        logic ana_step;
        logic ana_apply;
        logic rd_second;
        logic take_a1;
        logic pred_calc;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic adaptive;
        logic pred_possible;
        logic ana_go;
        logic ana_last;
        logic out_free;
    } status_t;

endpackage

FILE: src/stride_prefetch_predictor.sv
// ----------------------------------------------------------------------------
// stride_prefetch_predictor
// Adaptive stride predictor that records accesses and predicts the next one.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A predict item that can be served
// steps through PRD0, PRD1 and PCALC to its result; a record item that stores
// nothing goes straight to it. An adaptive-mode record writes the history, and
// on the pattern check the nine strides between slots 0 to 9 are read one per
// cycle through the single read port of the history memory and compared in one
// subtract-compare unit. The result sits in an output register, so the next
// item is taken while the previous result waits. Configuration writes take
// effect at once and must be made while no item is in flight.
module stride_prefetch_predictor
    import spp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,   // [0] action
    input  logic [ADDR_W-1:0]     s_tdata,   // [63:0] address
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,   // [0] prediction_valid
    output logic [M_TDATA_W-1:0]  m_tdata,   // [63:0] predicted_address,
                                             // [65:64] current_mode, rest zero
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    spp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    spp_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_address (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: src/spp_datapath.sv
// ----------------------------------------------------------------------------
// spp_datapath
// History memory, mode and stride registers, stride check unit and result
// register of the stride prefetch predictor.
// ----------------------------------------------------------------------------
module spp_datapath
    import spp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [ADDR_W-1:0]     in_address,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic [ADDR_W-1:0]     mem [HISTORY_DEPTH];
    logic [ADDR_W-1:0]     addr_reg;
    logic [FW-1:0]         fill_reg;
    logic [AW-1:0]         wrap_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [ADDR_W-1:0]     stride_reg;
    logic [MODE_W-1:0]     init_mode_reg;
    logic [ADDR_W-1:0]     init_stride_reg;
    logic [SPAN_CNT_W-1:0] cnt_reg;
    logic                  lin_reg;
    logic                  str_reg;
    logic [ADDR_W-1:0]     first_reg;
    logic [ADDR_W-1:0]     prev_reg;
    logic [ADDR_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]     a1_reg;
    logic [ADDR_W-1:0]     addend_reg;
    logic                  pred_ok_reg;
    logic                  out_valid_reg;
    logic                  out_pred_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [MODE_W-1:0]     out_mode_reg;

    logic                  full;
    logic [AW-1:0]         wrap_inc;
    logic [AW-1:0]         wrap_after;
    logic [FW-1:0]         fill_after;
    logic [AW-1:0]         wr_slot;
    logic [AW-1:0]         base;
    logic [AW-1:0]         newest;
    logic [AW-1:0]         second;
    logic [AW-1:0]         rd_addr;
    logic [ADDR_W-1:0]     diff;

    assign full       = (fill_reg == FW'(HISTORY_DEPTH));
    assign wrap_inc   = (wrap_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wrap_reg + 1'b1;
    assign wrap_after = full ? wrap_inc : wrap_reg;
    assign fill_after = full ? fill_reg : fill_reg + 1'b1;
    assign wr_slot    = full ? wrap_reg : fill_reg[AW-1:0];

    // Slot of the newest entry and the one written before it.
    assign base   = full ? wrap_reg : fill_reg[AW-1:0];
    assign newest = (base == '0) ? AW'(HISTORY_DEPTH - 1) : base - 1'b1;
    assign second = (newest == '0) ? AW'(HISTORY_DEPTH - 1) : newest - 1'b1;

    always_comb
    begin
        if (cmd.ana_step)
        begin
            rd_addr = (cnt_reg < SPAN_CNT_W'(SPAN)) ? AW'(cnt_reg) : '0;
        end
        else if (cmd.rd_second)
        begin
            rd_addr = second;
        end
        else
        begin
            rd_addr = newest;
        end
    end

    assign diff = rd_data_reg - prev_reg;

    assign status.adaptive      = (mode_reg == MODE_ADAPTIVE);
    assign status.pred_possible = (fill_reg >= FW'(2)) &&
                                  ((mode_reg == MODE_LINEAR) ||
                                   ((mode_reg == MODE_STRIDED) && (fill_reg >= FW'(3))));
    assign status.ana_go        = (wrap_after == '0) && (fill_after >= FW'(SPAN));
    assign status.ana_last      = (cnt_reg == SPAN_CNT_W'(SPAN));
    assign status.out_free      = !out_valid_reg || m_tready;

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_hist)
        begin
            mem[wr_slot] <= addr_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= in_address;
        end
        if (cmd.ana_step && (cnt_reg != '0))
        begin
            prev_reg <= rd_data_reg;
            if (cnt_reg == SPAN_CNT_W'(2))
            begin
                first_reg <= diff;
            end
        end
        if (cmd.take_a1)
        begin
            a1_reg <= rd_data_reg;
        end
        if (cmd.pred_calc)
        begin
            addend_reg <= (mode_reg == MODE_LINEAR) ? stride_reg : a1_reg - rd_data_reg;
        end
        if (cmd.load_out)
        begin
            out_pred_reg <= pred_ok_reg;
            out_addr_reg <= pred_ok_reg ? a1_reg + addend_reg : '0;
            out_mode_reg <= mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            wrap_reg        <= '0;
            mode_reg        <= MODE_ADAPTIVE;
            stride_reg      <= RESET_STRIDE;
            init_mode_reg   <= MODE_ADAPTIVE;
            init_stride_reg <= RESET_STRIDE;
            cnt_reg         <= '0;
            lin_reg         <= 1'b0;
            str_reg         <= 1'b0;
            pred_ok_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.wr_hist)
            begin
                fill_reg <= fill_after;
                wrap_reg <= wrap_after;
            end

            if (cmd.ana_start)
            begin
                cnt_reg <= '0;
                lin_reg <= 1'b1;
                str_reg <= 1'b1;
            end
            else if (cmd.ana_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg >= SPAN_CNT_W'(2))
                begin
                    lin_reg <= lin_reg && (diff == stride_reg);
                end
                if (cnt_reg > SPAN_CNT_W'(2))
                begin
                    str_reg <= str_reg && (diff == first_reg);
                end
            end

            // Either register write reloads both working values.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INITIAL_MODE:
                    begin
                        init_mode_reg <= cfg_data[MODE_W-1:0];
                        mode_reg      <= cfg_data[MODE_W-1:0];
                        stride_reg    <= init_stride_reg;
                    end
                    REG_INITIAL_STRIDE:
                    begin
                        init_stride_reg <= cfg_data;
                        mode_reg        <= init_mode_reg;
                        stride_reg      <= cfg_data;
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
            else if (cmd.ana_apply)
            begin
                if (lin_reg)
                begin
                    mode_reg <= MODE_LINEAR;
                end
                else if (str_reg)
                begin
                    mode_reg   <= MODE_STRIDED;
                    stride_reg <= first_reg;
                end
                else
                begin
                    mode_reg <= MODE_RANDOM;
                end
            end

            if (cmd.capture)
            begin
                pred_ok_reg <= 1'b0;
            end
            else if (cmd.pred_calc)
            begin
                pred_ok_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pred_reg;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - MODE_W){1'b0}}, out_mode_reg, out_addr_reg};

endmodule

FILE: src/spp_ctrl.sv
// ----------------------------------------------------------------------------
// spp_ctrl
// Sequencer of the stride prefetch predictor: accepts one item, steps the
// datapath through write, stride check or prediction, and hands off the result.
// ----------------------------------------------------------------------------
module spp_ctrl
    import spp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    action,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_ANA   = 3'd2;
    localparam logic [2:0] ST_AFIN  = 3'd3;
    localparam logic [2:0] ST_PRD0  = 3'd4;
    localparam logic [2:0] ST_PRD1  = 3'd5;
    localparam logic [2:0] ST_PCALC = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    if (action == ACTION_RECORD)
                    begin
                        state_next = status.adaptive ? ST_WRITE : ST_DONE;
                    end
                    else
                    begin
                        state_next = status.pred_possible ? ST_PRD0 : ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.wr_hist   = 1'b1;
                cmd.ana_start = 1'b1;
                state_next    = status.ana_go ? ST_ANA : ST_DONE;
            end
            ST_ANA:
            begin
                cmd.ana_step = 1'b1;
                if (status.ana_last)
                begin
                    state_next = ST_AFIN;
                end
            end
            ST_AFIN:
            begin
                cmd.ana_apply = 1'b1;
                state_next    = ST_DONE;
            end
            ST_PRD0:
            begin
                state_next = ST_PRD1;
            end
            ST_PRD1:
            begin
                cmd.rd_second = 1'b1;
                cmd.take_a1   = 1'b1;
                state_next    = ST_PCALC;
            end
            ST_PCALC:
            begin
                cmd.pred_calc = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: tb/sv/stride_prefetch_predictor_test.sv
// ----------------------------------------------------------------------------
// stride_prefetch_predictor_test
// Self-checking testbench of the stride prefetch predictor. Record and
// predict transfers go in through the slave stream, and each result from the
// master stream is checked against an in-bench copy of the predictor that
// keeps its own history ring, fill count, wrap pointer, mode and stride.
// Directed tests cover filling after reset, every mode and the stride
// extremes. Random phases then reprogram the registers and replay linear,
// strided, random and broken address runs, with predicts mixed in. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module stride_prefetch_predictor_test;
    import spp_pkg::*;

    localparam int DEPTH        = 16;
    localparam int SCAN_SPAN    = 10;
    localparam int DRAIN_CYCLES = 24;
    localparam int ITEM_TARGET  = 1950;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [MODE_W-1:0] mode;
    } guess_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic                 s_tuser;   // [0] action
    logic [ADDR_W-1:0]    s_tdata;   // [63:0] address
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 m_tuser;   // [0] prediction_valid
    logic [M_TDATA_W-1:0] m_tdata;   // [63:0] predicted_address, [65:64] current_mode
    logic                 cfg_we;
    logic                 cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    // Predictor state, updated at the edge where a transfer is accepted.
    logic [ADDR_W-1:0] hist_mem [DEPTH];
    int unsigned       hist_fill;
    int unsigned       wrap_slot;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_now;
    logic [ADDR_W-1:0] stride_reg;
    logic [ADDR_W-1:0] stride_now;

    guess_t      guess_q[$];
    int unsigned mismatches;
    int unsigned items_done;
    logic        steady_flow;

    stride_prefetch_predictor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Slot of the k-th newest entry; while the ring is filling the newest one
    // sits just below the fill count.
    function automatic int unsigned newest_slot(input int unsigned back);
        int unsigned base;
        base = (hist_fill < DEPTH) ? hist_fill : wrap_slot;
        return (base + DEPTH - 1 - back) % DEPTH;
    endfunction

    function automatic void classify_history();
        logic [ADDR_W-1:0] diff;
        logic [ADDR_W-1:0] first_diff;
        logic              all_working;
        logic              all_same;
        if (hist_fill < SCAN_SPAN)
            return;
        all_working = 1'b1;
        all_same    = 1'b1;
        first_diff  = hist_mem[1] - hist_mem[0];
        for (int i = 1; i < SCAN_SPAN; i++)
        begin
            diff = hist_mem[i] - hist_mem[i-1];
            if (diff != stride_now)
                all_working = 1'b0;
            if (diff != first_diff)
                all_same = 1'b0;
        end
        if (all_working)
            mode_now = MODE_LINEAR;
        else if (all_same)
        begin
            mode_now   = MODE_STRIDED;
            stride_now = first_diff;
        end
        else
            mode_now = MODE_RANDOM;
    endfunction

    function automatic guess_t predict_access(input logic act, input logic [ADDR_W-1:0] addr);
        guess_t            g;
        logic [ADDR_W-1:0] a1;
        logic [ADDR_W-1:0] a2;
        g.hit  = 1'b0;
        g.addr = '0;
        if (act == ACTION_RECORD)
        begin
            if (mode_now == MODE_ADAPTIVE)
            begin
                if (hist_fill < DEPTH)
                begin
                    hist_mem[hist_fill] = addr;
                    hist_fill++;
                end
                else
                begin
                    hist_mem[wrap_slot] = addr;
                    wrap_slot = (wrap_slot + 1) % DEPTH;
                end
                if (wrap_slot == 0)
                    classify_history();
            end
        end
        else if (hist_fill >= 2)
        begin
            a1 = hist_mem[newest_slot(0)];
            if (mode_now == MODE_LINEAR)
            begin
                g.hit  = 1'b1;
                g.addr = a1 + stride_now;
            end
            else if (mode_now == MODE_STRIDED && hist_fill >= 3)
            begin
                a2     = hist_mem[newest_slot(1)];
                g.hit  = 1'b1;
                g.addr = a1 + (a1 - a2);
            end
        end
        g.mode = mode_now;
        return g;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_stride();
        logic [ADDR_W-1:0] s;
        case ($urandom_range(0, 7))
            0: s = RESET_STRIDE;
            1: s = '0;
            2: s = 64'h8000_0000_0000_0000;
            3: s = 64'h7FFF_FFFF_FFFF_FFFF;
            4: s = {$urandom, $urandom};
            default:
            begin
                s = 64'($urandom_range(1, 64)) << $urandom_range(0, 6);
                if ($urandom_range(0, 1) == 1)
                    s = -s;
            end
        endcase
        return s;
    endfunction

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_INITIAL_MODE)
            mode_reg = value[MODE_W-1:0];
        else
            stride_reg = value;
        mode_now   = mode_reg;
        stride_now = stride_reg;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Valid stays high after a transfer unless the next item brings a gap,
    // so back-to-back items never lower and raise it in one step.
    task automatic send_access(input logic act, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act == ACTION_PREDICT || mode_now == MODE_ADAPTIVE)
            items_done++;
        guess_q = {guess_q, predict_access(act, addr)};
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (guess_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_fill_after_reset();
        logic [ADDR_W-1:0] base;
        base = '1;
        send_access(ACTION_PREDICT, '0);
        send_access(ACTION_RECORD, base);
        send_access(ACTION_PREDICT, '1);
        for (int k = 1; k < 9; k++)
            send_access(ACTION_RECORD, base + 64'(k) * RESET_STRIDE);
        send_access(ACTION_PREDICT, 64'h5555_5555_5555_5555);
        // The tenth record triggers the first pattern check.
        send_access(ACTION_RECORD, base + 64'd9 * RESET_STRIDE);
        send_access(ACTION_PREDICT, '0);
        send_access(ACTION_RECORD, '0);
        send_access(ACTION_PREDICT, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_config_registers();
        wait_idle();
        write_reg(REG_INITIAL_STRIDE, 64'h8000_0000_0000_0000);
        write_reg(REG_INITIAL_MODE, 64'(MODE_LINEAR));
        send_access(ACTION_PREDICT, '1);
        wait_idle();
        write_reg(REG_INITIAL_MODE, 64'(MODE_STRIDED));
        send_access(ACTION_PREDICT, '0);
        wait_idle();
        write_reg(REG_INITIAL_MODE, {62'h3FFF_FFFF_FFFF_FFFF, MODE_RANDOM});
        send_access(ACTION_PREDICT, '1);
        wait_idle();
        // History is kept, so this record lands in the eleventh slot while
        // the check still looks at slots 0 to 9.
        write_reg(REG_INITIAL_STRIDE, 64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(REG_INITIAL_MODE, 64'(MODE_ADAPTIVE));
        send_access(ACTION_RECORD, '0);
        send_access(ACTION_PREDICT, '0);
        wait_idle();
        write_reg(REG_INITIAL_STRIDE, RESET_STRIDE);
        send_access(ACTION_RECORD, '1);
        send_access(ACTION_PREDICT, '1);
    endtask

    task automatic test_random_patterns();
        int                n_rec;
        int                kind;
        int                which;
        int                noise_at;
        logic [MODE_W-1:0] mode_pick;
        logic [ADDR_W-1:0] stride_pick;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        while (items_done < ITEM_TARGET)
        begin
            wait_idle();
            steady_flow = ($urandom_range(0, 3) == 0);
            mode_pick   = ($urandom_range(0, 9) < 7) ? MODE_ADAPTIVE
                                                     : MODE_W'($urandom_range(0, 3));
            stride_pick = pick_stride();
            which       = $urandom_range(0, 3);
            if (which != 1)
                write_reg(REG_INITIAL_MODE, {$urandom, 30'($urandom_range(0, 32'h3FFF_FFFF)),
                                             mode_pick});
            if (which != 0)
                write_reg(REG_INITIAL_STRIDE, stride_pick);

            // In adaptive mode, send exactly the records that bring on the
            // next pattern check, so later phases start with the ring aligned.
            if (mode_now != MODE_ADAPTIVE)
                n_rec = $urandom_range(0, 3);
            else if (hist_fill < SCAN_SPAN)
                n_rec = SCAN_SPAN - hist_fill;
            else if (hist_fill < DEPTH)
                n_rec = 1;
            else
                n_rec = (wrap_slot == 0) ? DEPTH : DEPTH - wrap_slot;

            kind     = $urandom_range(0, 19);
            step     = (kind < 7) ? stride_now : pick_stride();
            base     = {$urandom, $urandom};
            noise_at = (kind >= 16 && n_rec > 0) ? $urandom_range(0, n_rec - 1) : -1;
            for (int i = 0; i < n_rec; i++)
            begin
                while ($urandom_range(0, 3) == 0)
                    send_access(ACTION_PREDICT, {$urandom, $urandom});
                if (kind >= 13 && kind < 16)
                    addr = {$urandom, $urandom};
                else
                    addr = base + 64'(i) * step;
                if (i == noise_at)
                    addr = addr + 64'($urandom_range(1, 32'hFFFF_FFFF));
                send_access(ACTION_RECORD, addr);
            end
            repeat ($urandom_range(1, 4))
                send_access(ACTION_PREDICT, {$urandom, $urandom});
        end
    endtask

    initial
    begin : result_check
        int     stall;
        guess_t want;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (guess_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual valid %0b addr %h mode %0d",
                         $time, m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: MODE_W]);
            end
            else
            begin
                want = guess_q.pop_front();
                if (m_tuser !== want.hit)
                begin
                    mismatches++;
                    $display("%0t: prediction_valid expected %0b actual %0b",
                             $time, want.hit, m_tuser);
                end
                if (m_tdata[ADDR_W-1:0] !== want.addr)
                begin
                    mismatches++;
                    $display("%0t: predicted_address expected %h actual %h",
                             $time, want.addr, m_tdata[ADDR_W-1:0]);
                end
                if (m_tdata[ADDR_W +: MODE_W] !== want.mode)
                begin
                    mismatches++;
                    $display("%0t: current_mode expected %0d actual %0d",
                             $time, want.mode, m_tdata[ADDR_W +: MODE_W]);
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = ACTION_RECORD;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_INITIAL_MODE;
        cfg_data    = '0;
        steady_flow = 1'b0;
        mismatches  = 0;
        items_done  = 0;
        hist_fill   = 0;
        wrap_slot   = 0;
        mode_reg    = MODE_ADAPTIVE;
        stride_reg  = RESET_STRIDE;
        mode_now    = mode_reg;
        stride_now  = stride_reg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_after_reset();
        test_config_registers();
        test_random_patterns();
        wait_idle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
src/spp_pkg.sv
src/spp_datapath.sv
src/spp_ctrl.sv
src/stride_prefetch_predictor.sv
tb/sv/stride_prefetch_predictor_test.sv
